[hw/rtl/lbpa_pkg.sv]
// lbpa_pkg: shared types, register map, reason codes and cordic table for the
// light bar pair armor check core; no dependencies
package lbpa_pkg;

  // register map
  localparam int NUM_REGS = 8;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  localparam logic [2:0] REG_MAX_HEIGHT_DIFF   = 3'd0;
  localparam logic [2:0] REG_MIN_CENTER_DIST   = 3'd1;
  localparam logic [2:0] REG_MAX_CENTER_DIST   = 3'd2;
  localparam logic [2:0] REG_MAX_ANGLE_DIFF    = 3'd3;
  localparam logic [2:0] REG_MIN_WH_RATIO      = 3'd4;
  localparam logic [2:0] REG_MAX_WH_RATIO      = 3'd5;
  localparam logic [2:0] REG_MIN_CB_RATIO      = 3'd6;
  localparam logic [2:0] REG_MAX_CB_RATIO      = 3'd7;

  localparam logic [15:0] RST_MAX_HEIGHT_DIFF  = 16'd160;
  localparam logic [16:0] RST_MIN_CENTER_DIST  = 17'd160;
  localparam logic [16:0] RST_MAX_CENTER_DIST  = 17'd8000;
  localparam logic [11:0] RST_MAX_ANGLE_DIFF   = 12'd240;
  localparam logic [15:0] RST_MIN_WH_RATIO     = 16'd256;
  localparam logic [15:0] RST_MAX_WH_RATIO     = 16'd1280;
  localparam logic [15:0] RST_MIN_CB_RATIO     = 16'd128;
  localparam logic [15:0] RST_MAX_CB_RATIO     = 16'd640;

  // reject reason codes
  localparam logic [2:0] REASON_OK       = 3'd0;
  localparam logic [2:0] REASON_LEN_DIFF = 3'd1;
  localparam logic [2:0] REASON_DIST     = 3'd2;
  localparam logic [2:0] REASON_ANGLE    = 3'd3;
  localparam logic [2:0] REASON_WH_RATIO = 3'd4;
  localparam logic [2:0] REASON_CB_RATIO = 3'd5;
  localparam logic [2:0] REASON_ZERO_LEN = 3'd6;

  // pipeline shape
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 17;

  // angle constants, degrees * 16 and degrees * 4096
  localparam logic signed [14:0] DEG90_X16   = 15'sd1440;
  localparam logic signed [14:0] DEG180_X16  = 15'sd2880;
  localparam logic signed [31:0] DEG180_X4K  = 32'sd737280;

  typedef struct packed {
    logic [15:0]        first_center_x;
    logic [15:0]        first_center_y;
    logic [15:0]        first_length;
    logic signed [11:0] first_tilt;
    logic [15:0]        second_center_x;
    logic [15:0]        second_center_y;
    logic [15:0]        second_length;
    logic signed [11:0] second_tilt;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         reject_reason;
    logic [15:0]        plate_center_x;
    logic [15:0]        plate_center_y;
    logic [16:0]        plate_width;
    logic [15:0]        plate_height;
    logic signed [11:0] plate_tilt;
  } out_item_t;

  // item plus the bar length product that ride along the pipe
  typedef struct packed {
    in_item_t    item;
    logic [31:0] len_prod;
  } side_t;

  // atan(2^-i) in degrees * 4096
  function automatic logic signed [31:0] cordic_atan(input int unsigned i);
    logic signed [31:0] v;
    v = '0;
    case (i)
      0:  v = 32'sd184320;
      1:  v = 32'sd108810;
      2:  v = 32'sd57492;
      3:  v = 32'sd29184;
      4:  v = 32'sd14649;
      5:  v = 32'sd7331;
      6:  v = 32'sd3667;
      7:  v = 32'sd1833;
      8:  v = 32'sd917;
      9:  v = 32'sd458;
      10: v = 32'sd229;
      11: v = 32'sd115;
      12: v = 32'sd57;
      13: v = 32'sd29;
      14: v = 32'sd14;
      15: v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/lbpa_if.sv]
// lbpa_if: valid/ready channel interfaces for pair items and plate results
// depends on lbpa_pkg
interface lbpa_in_if;
  logic               valid;
  logic               ready;
  lbpa_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lbpa_out_if;
  logic                valid;
  logic                ready;
  lbpa_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/light_bar_pair_armor_check_core.sv]
// light bar pair armor check core: checks one light bar pair per cycle unless
// the result is stalled, which freezes every stage
// the depth is set by the 17-step integer square root, one root bit per stage,
// with the 16-step cordic arctangent running beside it
// synchronous active-low reset clears valid bits and puts config registers
// to reset values; depends on lbpa_pkg and lbpa_if
module light_bar_pair_armor_check_core (
  input  logic                           clk,
  input  logic                           rst_n,
  lbpa_in_if.sink                        in_bus,
  lbpa_out_if.source                     out_bus,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lbpa_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [lbpa_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [lbpa_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);

  // stage map: 0 capture, 1 squares, 2..19 root/cordic slots, 20..21 checks, 22 out
  localparam int SQ0   = 2;
  localparam int ST_D  = SQ0 + lbpa_pkg::SQRT_STEPS + 1;
  localparam int ST_E  = ST_D + 1;
  localparam int ST_F  = ST_E + 1;
  localparam int NST   = ST_F + 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] max_height_diff_r;
  logic [16:0] min_center_dist_r;
  logic [16:0] max_center_dist_r;
  logic [11:0] max_angle_diff_r;
  logic [15:0] min_wh_ratio_r;
  logic [15:0] max_wh_ratio_r;
  logic [15:0] min_cb_ratio_r;
  logic [15:0] max_cb_ratio_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_height_diff_r <= lbpa_pkg::RST_MAX_HEIGHT_DIFF;
      min_center_dist_r <= lbpa_pkg::RST_MIN_CENTER_DIST;
      max_center_dist_r <= lbpa_pkg::RST_MAX_CENTER_DIST;
      max_angle_diff_r  <= lbpa_pkg::RST_MAX_ANGLE_DIFF;
      min_wh_ratio_r    <= lbpa_pkg::RST_MIN_WH_RATIO;
      max_wh_ratio_r    <= lbpa_pkg::RST_MAX_WH_RATIO;
      min_cb_ratio_r    <= lbpa_pkg::RST_MIN_CB_RATIO;
      max_cb_ratio_r    <= lbpa_pkg::RST_MAX_CB_RATIO;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lbpa_pkg::REG_MAX_HEIGHT_DIFF: max_height_diff_r <= cfg_pwdata[15:0];
        lbpa_pkg::REG_MIN_CENTER_DIST: min_center_dist_r <= cfg_pwdata[16:0];
        lbpa_pkg::REG_MAX_CENTER_DIST: max_center_dist_r <= cfg_pwdata[16:0];
        lbpa_pkg::REG_MAX_ANGLE_DIFF:  max_angle_diff_r  <= cfg_pwdata[11:0];
        lbpa_pkg::REG_MIN_WH_RATIO:    min_wh_ratio_r    <= cfg_pwdata[15:0];
        lbpa_pkg::REG_MAX_WH_RATIO:    max_wh_ratio_r    <= cfg_pwdata[15:0];
        lbpa_pkg::REG_MIN_CB_RATIO:    min_cb_ratio_r    <= cfg_pwdata[15:0];
        lbpa_pkg::REG_MAX_CB_RATIO:    max_cb_ratio_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      lbpa_pkg::REG_MAX_HEIGHT_DIFF: cfg_prdata = {16'd0, max_height_diff_r};
      lbpa_pkg::REG_MIN_CENTER_DIST: cfg_prdata = {15'd0, min_center_dist_r};
      lbpa_pkg::REG_MAX_CENTER_DIST: cfg_prdata = {15'd0, max_center_dist_r};
      lbpa_pkg::REG_MAX_ANGLE_DIFF:  cfg_prdata = {20'd0, max_angle_diff_r};
      lbpa_pkg::REG_MIN_WH_RATIO:    cfg_prdata = {16'd0, min_wh_ratio_r};
      lbpa_pkg::REG_MAX_WH_RATIO:    cfg_prdata = {16'd0, max_wh_ratio_r};
      lbpa_pkg::REG_MIN_CB_RATIO:    cfg_prdata = {16'd0, min_cb_ratio_r};
      lbpa_pkg::REG_MAX_CB_RATIO:    cfg_prdata = {16'd0, max_cb_ratio_r};
      default: cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline control: the whole pipe advances unless the result is stalled,
  // so empty slots are overwritten and a stall freezes every stage
  // ---------------------------------------------------------------------------
  logic           en;
  logic [NST-1:0] v_r;

  assign en           = !v_r[NST-1] || out_bus.ready;
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_bus.valid};
    end
  end

  // side line carrying the item itself
  lbpa_pkg::side_t side_r [0:ST_E];

  // ---------------------------------------------------------------------------
  // stage 1: deltas, squares and bar length product
  // ---------------------------------------------------------------------------
  logic signed [16:0] dx, dy;
  logic [15:0]        adx, ady;
  logic signed [16:0] dx_r, dy_r;
  logic [31:0]        sqx_r, sqy_r;

  always_comb begin
    dx  = $signed({1'b0, side_r[0].item.second_center_x})
        - $signed({1'b0, side_r[0].item.first_center_x});
    dy  = $signed({1'b0, side_r[0].item.second_center_y})
        - $signed({1'b0, side_r[0].item.first_center_y});
    adx = dx[16] ? 16'(-dx) : dx[15:0];
    ady = dy[16] ? 16'(-dy) : dy[15:0];
  end

  // ---------------------------------------------------------------------------
  // slot 0 setup: radicand and cordic pre-rotation into the right half plane
  // ---------------------------------------------------------------------------
  logic signed [16:0] ndx, ndy;
  logic signed [31:0] z_init;

  always_comb begin
    if (dx_r < 0) begin
      ndx    = -dx_r;
      ndy    = -dy_r;
      z_init = (dy_r >= 0) ? lbpa_pkg::DEG180_X4K : -lbpa_pkg::DEG180_X4K;
    end else begin
      ndx    = dx_r;
      ndy    = dy_r;
      z_init = '0;
    end
  end

  // root and cordic slots
  logic [33:0]        rem_r  [0:lbpa_pkg::SQRT_STEPS];
  logic [16:0]        root_r [0:lbpa_pkg::SQRT_STEPS];
  logic [33:0]        rem_nxt  [1:lbpa_pkg::SQRT_STEPS];
  logic [16:0]        root_nxt [1:lbpa_pkg::SQRT_STEPS];
  logic signed [31:0] cx_r [0:lbpa_pkg::CORDIC_STEPS];
  logic signed [31:0] cy_r [0:lbpa_pkg::CORDIC_STEPS];
  logic signed [31:0] cz_r [0:lbpa_pkg::CORDIC_STEPS];
  logic signed [31:0] cx_nxt [1:lbpa_pkg::CORDIC_STEPS];
  logic signed [31:0] cy_nxt [1:lbpa_pkg::CORDIC_STEPS];
  logic signed [31:0] cz_nxt [1:lbpa_pkg::CORDIC_STEPS];

  // one root bit per stage, remainder form: rem = n - root^2
  always_comb begin
    logic [35:0] trial;
    trial = '0;
    for (int j = 0; j < lbpa_pkg::SQRT_STEPS; j++) begin
      trial = ({19'd0, root_r[j]} << (lbpa_pkg::SQRT_STEPS - j))
            + (36'd1 << (2 * (lbpa_pkg::SQRT_STEPS - 1 - j)));
      if ({2'b00, rem_r[j]} >= trial) begin
        rem_nxt[j+1]  = rem_r[j] - trial[33:0];
        root_nxt[j+1] = root_r[j] | (17'd1 << (lbpa_pkg::SQRT_STEPS - 1 - j));
      end else begin
        rem_nxt[j+1]  = rem_r[j];
        root_nxt[j+1] = root_r[j];
      end
    end
  end

  // one cordic vectoring step per stage; a zero y stays put
  always_comb begin
    logic signed [31:0] xs, ys;
    xs = '0;
    ys = '0;
    for (int i = 0; i < lbpa_pkg::CORDIC_STEPS; i++) begin
      xs = cx_r[i] >>> i;
      ys = cy_r[i] >>> i;
      if (cy_r[i] > 0) begin
        cx_nxt[i+1] = cx_r[i] + ys;
        cy_nxt[i+1] = cy_r[i] - xs;
        cz_nxt[i+1] = cz_r[i] + lbpa_pkg::cordic_atan(i);
      end else if (cy_r[i] < 0) begin
        cx_nxt[i+1] = cx_r[i] - ys;
        cy_nxt[i+1] = cy_r[i] + xs;
        cz_nxt[i+1] = cz_r[i] - lbpa_pkg::cordic_atan(i);
      end else begin
        cx_nxt[i+1] = cx_r[i];
        cy_nxt[i+1] = cy_r[i];
        cz_nxt[i+1] = cz_r[i];
      end
    end
  end

  // line angle rounded to degrees * 16, lands with the last root bit
  logic signed [31:0] z_round;
  logic signed [13:0] ang_r;

  assign z_round = (cz_r[lbpa_pkg::CORDIC_STEPS] + 32'sd128) >>> 8;

  // ---------------------------------------------------------------------------
  // stage D: zero length, distance, angle, length checks and width/height products
  // ---------------------------------------------------------------------------
  function automatic logic signed [14:0] angle_gap(input logic signed [13:0] ang,
                                                   input logic signed [11:0] tilt);
    logic signed [14:0] d, alt;
    d   = $signed({ang[13], ang}) - ($signed({{3{tilt[11]}}, tilt}) + lbpa_pkg::DEG90_X16);
    d   = (d < 0) ? -d : d;
    alt = lbpa_pkg::DEG180_X16 - d;
    return (alt < d) ? alt : d;
  endfunction

  lbpa_pkg::in_item_t it_c;
  logic [16:0]        dist_c;
  logic [16:0]        lsum_c;
  logic [15:0]        ldiff_c;
  logic signed [14:0] lim_c;

  logic        zero_d_r, len_d_r, range_d_r, ang_d_r;
  logic [16:0] dist_d_r;
  logic [25:0] d512_d_r;
  logic [32:0] p4_d_r, p5_d_r;
  logic [33:0] mdl_d_r;

  always_comb begin
    it_c    = side_r[ST_D-1].item;
    dist_c  = root_r[lbpa_pkg::SQRT_STEPS];
    lsum_c  = {1'b0, it_c.first_length} + {1'b0, it_c.second_length};
    ldiff_c = (it_c.first_length > it_c.second_length)
            ? it_c.first_length - it_c.second_length
            : it_c.second_length - it_c.first_length;
    lim_c   = $signed({3'b000, max_angle_diff_r});
  end

  // ---------------------------------------------------------------------------
  // stage E: width/height compare and bar ratio products
  // ---------------------------------------------------------------------------
  logic        zero_e_r, len_e_r, range_e_r, ang_e_r, wh_e_r;
  logic [16:0] dist_e_r;
  logic [47:0] q6_e_r, q7_e_r;
  logic [39:0] m64_e_r;

  // ---------------------------------------------------------------------------
  // stage F: final reason and plate geometry
  // ---------------------------------------------------------------------------
  lbpa_pkg::in_item_t  it_e;
  logic                cb_fail;
  logic [2:0]          reason;
  logic [16:0]         sum_x, sum_y, sum_l;
  logic signed [12:0]  sum_t;
  lbpa_pkg::out_item_t res_nxt;
  lbpa_pkg::out_item_t res_r;

  always_comb begin
    it_e    = side_r[ST_E].item;
    cb_fail = ({8'd0, m64_e_r} < q6_e_r) || ({8'd0, m64_e_r} > q7_e_r);
    if (zero_e_r)       reason = lbpa_pkg::REASON_ZERO_LEN;
    else if (len_e_r)   reason = lbpa_pkg::REASON_LEN_DIFF;
    else if (range_e_r) reason = lbpa_pkg::REASON_DIST;
    else if (ang_e_r)   reason = lbpa_pkg::REASON_ANGLE;
    else if (wh_e_r)    reason = lbpa_pkg::REASON_WH_RATIO;
    else if (cb_fail)   reason = lbpa_pkg::REASON_CB_RATIO;
    else                reason = lbpa_pkg::REASON_OK;
    sum_x = {1'b0, it_e.first_center_x} + {1'b0, it_e.second_center_x};
    sum_y = {1'b0, it_e.first_center_y} + {1'b0, it_e.second_center_y};
    sum_l = {1'b0, it_e.first_length} + {1'b0, it_e.second_length};
    sum_t = $signed({it_e.first_tilt[11], it_e.first_tilt})
          + $signed({it_e.second_tilt[11], it_e.second_tilt});
    res_nxt               = '0;
    res_nxt.reject_reason = reason;
    if (reason == lbpa_pkg::REASON_OK) begin
      res_nxt.accepted       = 1'b1;
      res_nxt.plate_center_x = sum_x[16:1];
      res_nxt.plate_center_y = sum_y[16:1];
      res_nxt.plate_width    = dist_e_r;
      res_nxt.plate_height   = sum_l[16:1];
      res_nxt.plate_tilt     = sum_t[12:1];
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers, all frozen together on a stall
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      // capture
      side_r[0].item     <= in_bus.data;
      side_r[0].len_prod <= '0;
      // stage 1
      side_r[1].item     <= side_r[0].item;
      side_r[1].len_prod <= side_r[0].item.first_length * side_r[0].item.second_length;
      dx_r  <= dx;
      dy_r  <= dy;
      sqx_r <= adx * adx;
      sqy_r <= ady * ady;
      for (int k = 1; k < ST_E; k++) begin
        side_r[k+1] <= side_r[k];
      end
      // slot 0
      rem_r[0]  <= {2'b00, sqx_r} + {2'b00, sqy_r};
      root_r[0] <= '0;
      cx_r[0]   <= $signed({{15{ndx[16]}}, ndx}) <<< 12;
      cy_r[0]   <= $signed({{15{ndy[16]}}, ndy}) <<< 12;
      cz_r[0]   <= z_init;
      for (int j = 1; j <= lbpa_pkg::SQRT_STEPS; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
      end
      for (int i = 1; i <= lbpa_pkg::CORDIC_STEPS; i++) begin
        cx_r[i] <= cx_nxt[i];
        cy_r[i] <= cy_nxt[i];
        cz_r[i] <= cz_nxt[i];
      end
      ang_r <= z_round[13:0];
      // stage D
      zero_d_r  <= (it_c.first_length == 16'd0) || (it_c.second_length == 16'd0);
      len_d_r   <= ldiff_c > max_height_diff_r;
      range_d_r <= (dist_c < min_center_dist_r) || (dist_c > max_center_dist_r);
      ang_d_r   <= (angle_gap(ang_r, it_c.first_tilt) > lim_c)
                || (angle_gap(ang_r, it_c.second_tilt) > lim_c);
      dist_d_r  <= dist_c;
      d512_d_r  <= {dist_c, 9'd0};
      p4_d_r    <= min_wh_ratio_r * lsum_c;
      p5_d_r    <= max_wh_ratio_r * lsum_c;
      mdl_d_r   <= dist_c * lsum_c;
      // stage E
      zero_e_r  <= zero_d_r;
      len_e_r   <= len_d_r;
      range_e_r <= range_d_r;
      ang_e_r   <= ang_d_r;
      wh_e_r    <= ({7'd0, d512_d_r} < p4_d_r) || ({7'd0, d512_d_r} > p5_d_r);
      dist_e_r  <= dist_d_r;
      q6_e_r    <= min_cb_ratio_r * side_r[ST_D].len_prod;
      q7_e_r    <= max_cb_ratio_r * side_r[ST_D].len_prod;
      m64_e_r   <= {mdl_d_r, 6'd0};
      // stage F
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid = v_r[NST-1];
  assign out_bus.data  = res_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipe moved during stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> v_r[0])
    else $error("accepted transaction not captured");

  a_accept_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.data.accepted
      |-> out_bus.data.reject_reason == lbpa_pkg::REASON_OK)
    else $error("accepted plate with a reject reason");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.data.accepted |-> out_bus.data.plate_width == 17'd0
      && out_bus.data.plate_height == 16'd0)
    else $error("rejected plate carries geometry");

endmodule
